// File: design/mcld_pkg.sv
`default_nettype none

package mcld_pkg;

   // width of the level fields, fixed by the word format
   localparam int unsigned LEVEL_W     = 10;
   // channels fitted, 1 to LEVEL_W
   localparam int unsigned NUM_SENSORS = 10;

   localparam int unsigned PERIOD_W    = 8;
   localparam int unsigned COUNT_W     = 8;
   localparam int unsigned DT_LOW_W    = 64;
   localparam int unsigned DT_HIGH_W   = 16;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned CSR_DATA_W  = 64;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DT_LOW        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DT_HIGH       = 2'd2;

   localparam logic [PERIOD_W-1:0]  PERIOD_RESET      = 8'd100;

   // per-word control from the prescaler to the channel cells
   typedef struct packed {
      logic advance;   // a word is taken this cycle
      logic sample;    // this word performs a debounce sample
   } ctl_type;

   // status of one channel cell
   typedef struct packed {
      logic confirmed;       // current confirmed level
      logic confirmed_next;  // confirmed level after this cycle's word
   } chan_type;

endpackage

`default_nettype wire

// File: design/mcld_prescaler.sv
`default_nettype none

module mcld_prescaler (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            fire,
   input  wire logic [mcld_pkg::PERIOD_W-1:0]   period,
   output mcld_pkg::ctl_type                    ctl
);
   import mcld_pkg::*;

   logic [PERIOD_W-1:0] tick_ff;
   logic [PERIOD_W-1:0] tick_in;
   logic [PERIOD_W-1:0] bumped;
   logic                sample;

   always_comb begin
      // count saturates at the period, then compare
      bumped = (tick_ff < period) ? tick_ff + PERIOD_W'(1) : tick_ff;
      sample = (bumped >= period);
      if (fire) begin
         tick_in = sample ? '0 : bumped;
      end else begin
         tick_in = tick_ff;
      end
      ctl.advance = fire;
      ctl.sample  = sample;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
      end else begin
         tick_ff <= tick_in;
      end
   end

endmodule

`default_nettype wire

// File: design/mcld_channel.sv
`default_nettype none

module mcld_channel (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire mcld_pkg::ctl_type              ctl,
   input  wire logic                           raw,
   input  wire logic [mcld_pkg::COUNT_W-1:0]   debounce_time,
   output mcld_pkg::chan_type                  status
);
   import mcld_pkg::*;

   logic               prev_ff;
   logic               prev_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               confirmed_ff;
   logic               confirmed_in;
   logic               confirm;

   always_comb begin
      prev_in      = prev_ff;
      count_in     = count_ff;
      confirmed_in = confirmed_ff;
      confirm      = 1'b0;
      if (ctl.advance && ctl.sample) begin
         if (raw == prev_ff) begin
            // stable: count down, confirm on reaching or sitting at zero
            if (count_ff != '0) begin
               count_in = count_ff - COUNT_W'(1);
               confirm  = (count_ff == COUNT_W'(1));
            end else begin
               confirm  = 1'b1;
            end
            if (confirm) begin
               confirmed_in = raw;
            end
         end else begin
            prev_in  = raw;
            count_in = debounce_time;
         end
      end
      status.confirmed      = confirmed_ff;
      status.confirmed_next = confirmed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff      <= 1'b0;
         count_ff     <= '0;
         confirmed_ff <= 1'b0;
      end else begin
         prev_ff      <= prev_in;
         count_ff     <= count_in;
         confirmed_ff <= confirmed_in;
      end
   end

endmodule

`default_nettype wire

// File: design/multi_channel_level_debounce.sv
// multi-channel level debounce
//
// req channel: one word per 1 ms tick, carrying the raw level of each sensor
// in req_raw_levels (bit i for channel i). rsp channel: one word per req word,
// carrying the debounced levels after that tick and a flag telling whether the
// tick performed a debounce sample.
// csr channel: register writes by index (0 sample period, 1 debounce times of
// channels 0 to 7, 2 debounce times of channels 8 and 9); always ready, and
// only to be used while no word is in flight.
//
// the rsp word is registered and valid the cycle after its req word is taken.
// one word per cycle unless the receiver stalls; the whole update is a single pass through
// the prescaler and the per-channel cells into the rsp register.
// a req word is taken whenever the rsp register is empty or being emptied,
// so a stalled receiver holds req_ready low only while its word is unread.
//
// reset: prescaler, samples, counters and confirmed levels clear to zero,
// the sample period returns to 100 and the debounce times to zero.
`default_nettype none

module multi_channel_level_debounce (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // tick words
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [mcld_pkg::LEVEL_W-1:0]      req_raw_levels,
   // result words
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [mcld_pkg::LEVEL_W-1:0]           rsp_confirmed_levels,
   output logic                                   rsp_sampled,
   // register writes
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [mcld_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mcld_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mcld_pkg::*;

   // configuration registers
   logic [PERIOD_W-1:0]  period_ff;
   logic [DT_LOW_W-1:0]  dt_low_ff;
   logic [DT_HIGH_W-1:0] dt_high_ff;

   // result register
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [LEVEL_W-1:0]   rsp_levels_ff;
   logic [LEVEL_W-1:0]   rsp_levels_in;
   logic                 rsp_sampled_ff;
   logic                 rsp_sampled_in;

   logic                 fire;
   ctl_type              ctl;
   chan_type             status [LEVEL_W];
   logic [LEVEL_W-1:0]   confirmed_now;
   logic [LEVEL_W-1:0]   confirmed_next;

   // a word enters when the result register is free or is being read
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign fire      = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // register writes, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= PERIOD_RESET;
         dt_low_ff  <= '0;
         dt_high_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_SAMPLE_PERIOD: period_ff  <= csr_wdata[PERIOD_W-1:0];
            REG_DT_LOW:        dt_low_ff  <= csr_wdata[DT_LOW_W-1:0];
            REG_DT_HIGH:       dt_high_ff <= csr_wdata[DT_HIGH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   mcld_prescaler u_prescaler (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .period (period_ff),
      .ctl    (ctl)
   );

   // one cell per fitted channel; unfitted bits read zero
   for (genvar ch = 0; ch < LEVEL_W; ch++) begin : g_chan
      if (ch < NUM_SENSORS) begin : g_fitted
         logic [COUNT_W-1:0] dtime;
         if (ch < 8) begin : g_low
            assign dtime = dt_low_ff[COUNT_W*ch +: COUNT_W];
         end else begin : g_high
            assign dtime = dt_high_ff[COUNT_W*(ch-8) +: COUNT_W];
         end
         mcld_channel u_channel (
            .clock         (clock),
            .reset         (reset),
            .ctl           (ctl),
            .raw           (req_raw_levels[ch]),
            .debounce_time (dtime),
            .status        (status[ch])
         );
      end else begin : g_unfitted
         assign status[ch] = '0;
      end
      assign confirmed_now[ch]  = status[ch].confirmed;
      assign confirmed_next[ch] = status[ch].confirmed_next;
   end

   // result register loads on every accepted word
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_levels_in  = rsp_levels_ff;
      rsp_sampled_in = rsp_sampled_ff;
      if (fire) begin
         rsp_valid_in   = 1'b1;
         rsp_levels_in  = confirmed_next;
         rsp_sampled_in = ctl.sample;
      end else if (rsp_ready) begin
         rsp_valid_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         rsp_levels_ff  <= '0;
         rsp_sampled_ff <= 1'b0;
      end else begin
         rsp_valid_ff   <= rsp_valid_in;
         rsp_levels_ff  <= rsp_levels_in;
         rsp_sampled_ff <= rsp_sampled_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_confirmed_levels = rsp_levels_ff;
   assign rsp_sampled          = rsp_sampled_ff;

`ifndef SYNTHESIS
   // every taken word leaves a result behind
   a_word_gives_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid)
      else $error("accepted word produced no result");

   // the result register always mirrors the cells' confirmed levels
   a_result_matches_cells: assert property (@(posedge clock) disable iff (reset)
      rsp_confirmed_levels == confirmed_now)
      else $error("result levels differ from channel state");

   // a tick without a sample cannot move a confirmed level
   a_no_sample_no_change: assert property (@(posedge clock) disable iff (reset)
      (fire && !ctl.sample) |=> (rsp_confirmed_levels == $past(rsp_confirmed_levels)))
      else $error("confirmed level changed without a sample");
`endif

endmodule

`default_nettype wire
